@@ hdl/r2fft_pkg.sv @@
package r2fft_pkg;

  // Frame geometry
  localparam int POINTS = 1024;
  localparam int LG     = $clog2(POINTS);
  localparam int HALF   = POINTS / 2;
  localparam int SW     = $clog2(LG);
  localparam int IDX_W  = 10;
  localparam int DW     = 28;
  localparam int TW_W   = 17;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic {
    OP_LOAD,
    OP_READ
  } op_e;

  // Classified input word
  typedef struct packed {
    op_e                op;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               inv;
  } cmd_t;

  // Result word
  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic [IDX_W-1:0]     idx;
    logic                 last;
    logic                 valid;
  } res_t;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic signed [TW_W-1:0] c;
    logic signed [TW_W-1:0] s;
  } tw_t;

  function automatic logic [LG-1:0] bitrev(input logic [LG-1:0] v);
    logic [LG-1:0] r;
    for (int b = 0; b < LG; b++) begin
      r[LG-1-b] = v[b];
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] sat28(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd134217727;
    lo = -32'sd134217728;
    if (v > hi) return DW'(hi);
    if (v < lo) return DW'(lo);
    return DW'(v);
  endfunction

  function automatic logic signed [TW_W-1:0] to_q15(input longint q30);
    longint r;
    r = (q30 + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < 64'sd0) r = 64'sd0;
    return TW_W'(r);
  endfunction

  // cos and sin of 2*pi*m/POINTS over the first octant, Taylor series in Q2.30
  function automatic tw_t octant(input int unsigned m);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned ts;
    longint unsigned tc;
    longint ss;
    longint cs;
    tw_t res;
    x  = (PI_Q30 * 64'd2 * 64'(m)) / POINTS;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    ss = longint'(x);
    cs = longint'(tc);
    for (int n = 1; n <= 5; n++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
      end
    end
    res.c = to_q15(cs);
    res.s = to_q15(ss);
    return res;
  endfunction

  // Twiddle for index k < POINTS/2, elaborated as a constant table
  function automatic tw_t twiddle(input int unsigned k);
    int unsigned q;
    int unsigned e;
    int unsigned m;
    tw_t o;
    tw_t w;
    q = POINTS / 4;
    e = POINTS / 8;
    m = (k < q) ? k : k - q;
    if (m <= e) begin
      o = octant(m);
    end else begin
      w   = octant(q - m);
      o.c = w.s;
      o.s = w.c;
    end
    if (k < q) begin
      return o;
    end
    w.c = -o.s;
    w.s = o.c;
    return w;
  endfunction

endpackage

@@ hdl/r2fft_front.sv @@
module r2fft_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic               action_i,
  input  logic signed [15:0] sample_real_i,
  input  logic signed [15:0] sample_imag_i,
  input  logic               inverse_i,
  output logic               cmd_valid_o,
  output r2fft_pkg::cmd_t    cmd_o,
  input  logic               cmd_pop_i
);

  localparam int Depth = 4;
  localparam int AW    = $clog2(Depth);

  r2fft_pkg::cmd_t fifo_q [Depth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [AW:0]     cnt_q;
  logic            wr_en, rd_en;
  r2fft_pkg::cmd_t cmd_in;

  // classify the incoming word
  always_comb begin
    cmd_in.op  = action_i ? r2fft_pkg::OP_READ : r2fft_pkg::OP_LOAD;
    cmd_in.re  = sample_real_i;
    cmd_in.im  = sample_imag_i;
    cmd_in.inv = inverse_i;
  end

  assign full_o      = (cnt_q == (AW+1)'(Depth));
  assign cmd_valid_o = (cnt_q != '0);
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
      else if (rd_en && !wr_en) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ hdl/r2fft_outq.sv @@
module r2fft_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  r2fft_pkg::res_t res_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output r2fft_pkg::res_t res_o
);

  localparam int Depth = 2;
  localparam int AW    = $clog2(Depth);

  r2fft_pkg::res_t fifo_q [Depth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [AW:0]     cnt_q;
  logic            wr_en, rd_en;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign res_o   = fifo_q[rd_ptr_q];

  // result storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= res_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
      else if (rd_en && !wr_en) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ hdl/r2fft_core.sv @@
module r2fft_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  r2fft_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  input  logic            out_full_i,
  output logic            out_push_o,
  output r2fft_pkg::res_t res_o
);

  localparam int LG     = r2fft_pkg::LG;
  localparam int SW     = r2fft_pkg::SW;
  localparam int DW     = r2fft_pkg::DW;
  localparam int TW     = r2fft_pkg::TW_W;
  localparam int IdxW   = r2fft_pkg::IDX_W;
  localparam int Npts   = r2fft_pkg::POINTS;
  localparam int Nquart = r2fft_pkg::HALF / 2;
  localparam int PW     = DW + TW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OUT,
    S_RD,
    S_MUL,
    S_ADD,
    S_WRP,
    S_WRI
  } state_e;

  state_e          state_q;
  logic [LG-1:0]   load_cnt_q, read_cnt_q;
  logic [SW-1:0]   stage_q;
  logic [LG-2:0]   bfly_q;
  logic            dir_q, ready_q, hit_q;

  r2fft_pkg::cplx_t mem [Npts];
  r2fft_pkg::cplx_t a_q, b_q;
  r2fft_pkg::tw_t   tw_rom [Nquart];
  r2fft_pkg::tw_t   tw_q;
  r2fft_pkg::tw_t   tw_base, tw_sel;
  logic signed [PW-1:0] m_rc_q, m_is_q, m_rs_q, m_ic_q;
  logic signed [30:0]   tr_q, ti_q;

  logic             is_load, is_read, last_bfly, last_stage;
  logic [LG-2:0]    jmask, jpart, hpart;
  logic [LG-1:0]    addr_i, addr_p, addr_a;
  logic [LG-2:0]    tw_k;
  logic             rd_en, wr_en;
  logic [LG-1:0]    wr_addr;
  r2fft_pkg::cplx_t wr_data;
  logic signed [TW-1:0] ws;
  logic signed [PW:0]   sum_r, sum_i;
  logic signed [DW:0]   sc_re, sc_im;

  // twiddle table for the first quadrant, constant at elaboration
  for (genvar g = 0; g < Nquart; g++) begin : g_tw
    assign tw_rom[g] = r2fft_pkg::twiddle(g);
  end

  // second quadrant: rotate by a quarter turn
  always_comb begin
    tw_base = tw_rom[tw_k[LG-3:0]];
    tw_sel  = tw_base;
    if (tw_k[LG-2]) begin
      tw_sel.c = -tw_base.s;
      tw_sel.s = tw_base.c;
    end
  end

  assign is_load    = cmd_valid_i && (cmd_i.op == r2fft_pkg::OP_LOAD);
  assign is_read    = cmd_valid_i && (cmd_i.op == r2fft_pkg::OP_READ);
  assign cmd_pop_o  = (state_q == S_IDLE) && cmd_valid_i;
  assign last_bfly  = (bfly_q == '1);
  assign last_stage = (stage_q == SW'(LG - 1));

  // butterfly addressing: insert a zero bit at the stage position
  always_comb begin
    jmask  = (LG-1)'((1 << stage_q) - 1);
    jpart  = bfly_q & jmask;
    hpart  = bfly_q & ~jmask;
    addr_i = {hpart, 1'b0} | {1'b0, jpart};
    addr_p = addr_i | LG'(1 << stage_q);
    tw_k   = (LG-1)'(jpart << (SW'(LG - 1) - stage_q));
  end

  // memory port selection
  always_comb begin
    rd_en   = (state_q == S_RD) || ((state_q == S_IDLE) && is_read);
    addr_a  = (state_q == S_RD) ? addr_i : read_cnt_q;
    wr_en   = ((state_q == S_IDLE) && is_load) || (state_q == S_WRP) || (state_q == S_WRI);
    wr_addr = r2fft_pkg::bitrev(load_cnt_q);
    wr_data.re = DW'(cmd_i.re);
    wr_data.im = DW'(cmd_i.im);
    if (state_q == S_WRP) begin
      wr_addr    = addr_p;
      wr_data.re = r2fft_pkg::sat28(32'(a_q.re) - 32'(tr_q));
      wr_data.im = r2fft_pkg::sat28(32'(a_q.im) - 32'(ti_q));
    end else if (state_q == S_WRI) begin
      wr_addr    = addr_i;
      wr_data.re = r2fft_pkg::sat28(32'(a_q.re) + 32'(tr_q));
      wr_data.im = r2fft_pkg::sat28(32'(a_q.im) + 32'(ti_q));
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      a_q <= mem[addr_a];
      b_q <= mem[addr_p];
    end
  end

  // butterfly datapath
  assign ws    = dir_q ? tw_q.s : -tw_q.s;
  assign sum_r = (PW+1)'(m_rc_q) - (PW+1)'(m_is_q) + (PW+1)'(16384);
  assign sum_i = (PW+1)'(m_rs_q) + (PW+1)'(m_ic_q) + (PW+1)'(16384);

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      tw_q <= tw_sel;
    end
    if (state_q == S_MUL) begin
      m_rc_q <= PW'(b_q.re * tw_q.c);
      m_is_q <= PW'(b_q.im * ws);
      m_rs_q <= PW'(b_q.re * ws);
      m_ic_q <= PW'(b_q.im * tw_q.c);
    end
    if (state_q == S_ADD) begin
      tr_q <= 31'(sum_r >>> 15);
      ti_q <= 31'(sum_i >>> 15);
    end
  end

  // readout with inverse scaling by 1/N, rounded
  always_comb begin
    sc_re = (DW+1)'(a_q.re);
    sc_im = (DW+1)'(a_q.im);
    if (dir_q) begin
      sc_re = (sc_re + (DW+1)'(1 << (LG - 1))) >>> LG;
      sc_im = (sc_im + (DW+1)'(1 << (LG - 1))) >>> LG;
    end
    res_o.valid = hit_q;
    res_o.re    = hit_q ? DW'(sc_re) : '0;
    res_o.im    = hit_q ? DW'(sc_im) : '0;
    res_o.idx   = hit_q ? IdxW'(read_cnt_q) : '0;
    res_o.last  = hit_q && (read_cnt_q == LG'(Npts - 1));
  end

  assign out_push_o = (state_q == S_OUT) && !out_full_i;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      load_cnt_q <= '0;
      read_cnt_q <= '0;
      stage_q    <= '0;
      bfly_q     <= '0;
      dir_q      <= 1'b0;
      ready_q    <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (is_load) begin
            if (load_cnt_q == '0) begin
              dir_q      <= cmd_i.inv;
              ready_q    <= 1'b0;
              read_cnt_q <= '0;
            end
            load_cnt_q <= load_cnt_q + 1'b1;
            if (load_cnt_q == LG'(Npts - 1)) begin
              stage_q <= '0;
              bfly_q  <= '0;
              state_q <= S_RD;
            end
          end else if (is_read) begin
            hit_q   <= ready_q;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_full_i) begin
            if (hit_q) begin
              read_cnt_q <= read_cnt_q + 1'b1;
              if (read_cnt_q == LG'(Npts - 1)) ready_q <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end
        S_RD:  state_q <= S_MUL;
        S_MUL: state_q <= S_ADD;
        S_ADD: state_q <= S_WRP;
        S_WRP: state_q <= S_WRI;
        S_WRI: begin
          bfly_q <= bfly_q + 1'b1;
          if (last_bfly) begin
            if (last_stage) begin
              ready_q    <= 1'b1;
              read_cnt_q <= '0;
              state_q    <= S_IDLE;
            end else begin
              stage_q <= stage_q + 1'b1;
              state_q <= S_RD;
            end
          end else begin
            state_q <= S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_ready_in_fft: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_MUL || state_q == S_ADD ||
     state_q == S_WRP || state_q == S_WRI) |-> !ready_q)
    else $error("transform running while a result is marked ready");
  a_push_only_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> (state_q == S_OUT))
    else $error("result pushed outside readout");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == S_IDLE))
    else $error("command taken while busy");
  a_done_sets_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRI && last_bfly && last_stage) |=> (ready_q && state_q == S_IDLE))
    else $error("transform end did not publish the frame");
`endif

endmodule

@@ hdl/radix2_complex_fft.sv @@
// Radix-2 decimation-in-time FFT, 1024 points, forward or inverse.
// Input channel: a queue side (push/full); a word is taken when push is
// high and full low. action 0 loads one sample, action 1 requests the next
// bin. The inverse bit of the first sample of a frame sets the direction.
// Result channel: a queue side (empty/pop); the oldest result is on the
// bin ports while empty is low and leaves when pop is high.
// Each word waits in the input queue until the core, while idle, takes it.
// A load is written to the frame store; a read puts its bin into the
// result queue once that queue has room. Samples are stored at
// bit-reversed addresses, so the transform starts right after the last
// sample: N/2*log2(N) = 5120 butterflies, each done as a read, multiply,
// round and two writes on one port.
// A 4-word input queue keeps taking words during the transform, then full
// rises. A read with no finished frame returns valid_res 0.
// Reset clears all control state; the frame store is not cleared. When the
// receiver stalls, the 2-word result queue fills and reads stall the core.
module radix2_complex_fft (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               action_i,
  input  logic signed [15:0] sample_real_i,
  input  logic signed [15:0] sample_imag_i,
  input  logic               inverse_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [27:0] bin_real_o,
  output logic signed [27:0] bin_imag_o,
  output logic [9:0]         bin_index_o,
  output logic               last_bin_o,
  output logic               valid_res_o
);

  logic            cmd_valid, cmd_pop, out_full, out_push;
  r2fft_pkg::cmd_t cmd;
  r2fft_pkg::res_t res_core, res_out;

  r2fft_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .action_i      (action_i),
    .sample_real_i (sample_real_i),
    .sample_imag_i (sample_imag_i),
    .inverse_i     (inverse_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  r2fft_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .res_o       (res_core)
  );

  r2fft_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .res_i   (res_core),
    .full_o  (out_full),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res_out)
  );

  assign bin_real_o  = res_out.re;
  assign bin_imag_o  = res_out.im;
  assign bin_index_o = res_out.idx;
  assign last_bin_o  = res_out.last;
  assign valid_res_o = res_out.valid;

endmodule
